// ----- rtl/b64e_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the sextet-to-character function for the base64 encoder.
// No dependencies.
package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       end_mark;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            end_mark;
  } entry_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) return CHAR_UPPER + w;
      else if (v < 6'd52) return CHAR_LOWER + w - 8'd26;
      else if (v < 6'd62) return CHAR_DIGIT + w - 8'd52;
      else if (v == 6'd62) return CHAR_PLUS;
      else return CHAR_SLASH;
    end
  endfunction

endpackage

// ----- rtl/b64e_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks group phase and carry bits, builds one character entry.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output entry_t   q_entry
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;
  logic [7:0] b;
  logic       fin;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign b        = in_data.data_byte;
  assign fin      = in_data.final_byte;

  always_comb begin
    phase_next = phase;
    carry_next = carry;
    if (q_push) begin
      unique case (phase)
        PH_ONE: begin
          phase_next = fin ? PH_START : PH_TWO;
          carry_next = fin ? 4'd0 : b[3:0];
        end
        PH_TWO: begin
          phase_next = PH_START;
          carry_next = 4'd0;
        end
        default: begin
          phase_next = fin ? PH_START : PH_ONE;
          carry_next = fin ? 4'd0 : {2'b00, b[1:0]};
        end
      endcase
    end
  end

  always_comb begin
    q_entry = '0;
    unique case (phase)
      PH_ONE: begin
        q_entry.chars[0] = sextet_char({carry[1:0], b[7:4]});
        q_entry.chars[1] = sextet_char({b[3:0], 2'b00});
        q_entry.chars[2] = CHAR_PAD;
        q_entry.last_idx = fin ? 2'd2 : 2'd0;
        q_entry.end_mark = fin;
      end
      PH_TWO: begin
        q_entry.chars[0] = sextet_char({carry, b[7:6]});
        q_entry.chars[1] = sextet_char(b[5:0]);
        q_entry.last_idx = 2'd1;
        q_entry.end_mark = fin;
      end
      default: begin
        q_entry.chars[0] = sextet_char(b[7:2]);
        q_entry.chars[1] = sextet_char({b[1:0], 4'b0000});
        q_entry.chars[2] = CHAR_PAD;
        q_entry.chars[3] = CHAR_PAD;
        q_entry.last_idx = fin ? 2'd3 : 2'd0;
        q_entry.end_mark = fin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      carry <= 4'd0;
    end else begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

// ----- rtl/b64e_queue.sv -----
`timescale 1ns / 1ps
// Short queue of character entries between front and back ends.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntFull);
  assign nonempty = (count != '0);
  assign head     = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/b64e_back.sv -----
`timescale 1ns / 1ps
// Back end: steps through an entry's characters into the output register.
// Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  entry_t    q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  entry_t     cur;
  logic [1:0] idx;
  logic       busy;
  logic       load;
  logic       last;

  assign load  = !out_valid || !out_stall;
  assign last  = (idx == cur.last_idx);
  assign q_pop = q_nonempty && (!busy || (load && last));

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (load && busy) begin
      out_data.code_char <= cur.chars[idx];
      out_data.end_mark  <= cur.end_mark && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= busy;
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (load && busy) begin
        if (last) busy <= 1'b0;
        else idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/base64_stream_encoder.sv -----
`timescale 1ns / 1ps
// Base64 stream encoder top level: front end, entry queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Input channel in_valid/in_stall/in_data carries one message byte and a
// last-of-message flag. Output channel out_valid/out_stall/out_data carries
// one base64 character per request, with end_mark set on the final
// character of a message ('=' padding included).
// Each byte turns into one entry of one to four characters in the front
// end and waits in a queue of QueueDepth entries. While the receiver does not
// stall, the back end sends one character per cycle from the head entry through
// an output register. The first character of a byte passes through the queue
// store, the back end's entry register and the output register. A middle-of-group
// byte yields one character, a group-closing byte two and a final byte up to four,
// so the output port sets the rate at which bytes are taken.
// When the receiver stalls, the output register holds its character, the
// queue fills and in_stall rises once it is full.
// Reset clears group phase, carry bits, queue and output valid; the next
// byte starts a new group.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_entry;
  entry_t q_head;

  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- verif/base64_stream_encoder_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: a burst driver, a stalling receiver
// and a clocked monitor that checks each character against a padded-base64 predictor.
// Depends on b64e_pkg and the base64_stream_encoder RTL.
module base64_stream_encoder_test;
  import b64e_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 60;
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [47:0] FOOBAR = "foobar";

  typedef enum logic [1:0] {
    NO_STALL    = 2'd0,
    LIGHT_STALL = 2'd1,
    HEAVY_STALL = 2'd2,
    ALT_STALL   = 2'd3
  } stall_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  base64_stream_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_item_t  pending_reqs[$];
  out_item_t expected_chars[$];
  phase_t    enc_phase = PH_START;
  logic [3:0] enc_carry = 4'd0;

  int  reqs_sent = 0;
  int  chars_seen = 0;
  int  messages_seen = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  req_taken = 1'b0;
  int  burst_left = 4;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic [7:0] stall_tick = 8'd0;
  out_item_t  want;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - v) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    out_item_t o;
    o.code_char = c;
    o.end_mark = last;
    expected_chars.push_back(o);
  endtask

  // Update the group phase and carried bits, queue the characters this byte yields.
  task automatic encode_byte(input in_item_t r);
    logic [7:0] b;
    logic fin;
    b = r.data_byte;
    fin = r.final_byte;
    case (enc_phase)
      PH_ONE: begin
        push_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(b64_char({b[3:0], 2'b00}), 1'b0);
          push_char(CHAR_PAD, 1'b1);
        end else begin
          enc_carry = b[3:0];
          enc_phase = PH_TWO;
        end
      end
      PH_TWO: begin
        push_char(b64_char({enc_carry, b[7:6]}), 1'b0);
        push_char(b64_char(b[5:0]), fin);
        enc_carry = 4'd0;
        enc_phase = PH_START;
      end
      default: begin
        push_char(b64_char(b[7:2]), 1'b0);
        if (fin) begin
          push_char(b64_char({b[1:0], 4'b0000}), 1'b0);
          push_char(CHAR_PAD, 1'b0);
          push_char(CHAR_PAD, 1'b1);
        end else begin
          enc_carry = {2'b00, b[1:0]};
          enc_phase = PH_ONE;
        end
      end
    endcase
    if (fin) begin
      enc_phase = PH_START;
      enc_carry = 4'd0;
    end
  endtask

  task automatic queue_req(input logic [7:0] b, input logic fin);
    in_item_t r;
    r.data_byte = b;
    r.final_byte = fin;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_foobar(input int len);
    for (int i = 0; i < len; i++)
      queue_req(FOOBAR[8 * (5 - i) +: 8], i == len - 1);
  endtask

  // Driver: bursts of requests with random gaps; hold a request until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off once traffic is flowing, otherwise a rotating stall pattern.
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && reqs_sent >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode_t'(stall_tick[7:6]))
        NO_STALL:    out_stall <= 1'b0;
        LIGHT_STALL: out_stall <= ($urandom_range(0, 3) == 0);
        HEAVY_STALL: out_stall <= 1'($urandom_range(0, 1));
        default:     out_stall <= stall_tick[0];
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted character.
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        reqs_sent++;
        encode_byte(in_data);
      end
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (out_data.end_mark)
          messages_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: code_char %h end_mark %b",
                 out_data.code_char, out_data.end_mark);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.code_char !== want.code_char) begin
            $error("code_char: expected %h, got %h", want.code_char, out_data.code_char);
            errors++;
          end
          if (out_data.end_mark !== want.end_mark) begin
            $error("end_mark: expected %b, got %b", want.end_mark, out_data.end_mark);
            errors++;
          end
        end
      end
      if (req_taken || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or character moved for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int total;
    int len;

    // Directed: standard vectors, all-zero and all-ones bytes, every group position.
    queue_foobar(1);
    queue_foobar(2);
    queue_foobar(3);
    queue_foobar(6);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req(8'h00, 1'b1);

    total = pending_reqs.size();
    while (total < 200) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        queue_req(8'($urandom_range(0, 255)), i == len - 1);
      total += len;
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (reqs_sent < total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("encoded %0d bytes into %0d characters over %0d messages", reqs_sent,
             chars_seen, messages_seen);
    $display("random bursts and gaps on input, rotating stalls and one %0d-cycle hold on output",
             HOLD_CYCLES);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
